// File: sv/utx_pkg.sv
// Package for the UTF-16/UTF-32 to UTF-8 transcoder.
// Holds the status codes, code point constants and the queue word type.
`timescale 1ns / 1ps

package utx_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_BAD_PAIR  = 3'd2,
    ST_LONE_LOW  = 3'd3,
    ST_INVALID   = 3'd4
  } status_e;

  localparam logic [15:0] SurHiFirst   = 16'hD800;
  localparam logic [15:0] SurHiLast    = 16'hDBFF;
  localparam logic [15:0] SurLoFirst   = 16'hDC00;
  localparam logic [15:0] SurLoLast    = 16'hDFFF;
  localparam logic [20:0] SuppBase     = 21'h10000;
  localparam logic [31:0] MaxCodePoint = 32'h0010FFFF;

  localparam logic [7:0] Lead2    = 8'hC0;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;
  localparam logic [5:0] ContMask = 6'h3F;

  // One queue word: a code point to encode, or an error (cp zero, one byte).
  typedef struct packed {
    logic [20:0] cp;
    logic [1:0]  last_idx;  // byte count minus one
    logic        eot;
    status_e     status;
  } job_t;

  function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
    logic [1:0] n;
    if (cp <= 21'h7F) begin
      n = 2'd0;
    end else if (cp <= 21'h7FF) begin
      n = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

// File: sv/utx_if.sv
// Channel interfaces of the transcoder: input word, output byte, mode write.
// Depends on utx_pkg for the status type.
`timescale 1ns / 1ps

interface utx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_unit;
  logic        end_of_text;

  modport source (output valid, code_unit, end_of_text, input ready);
  modport sink (input valid, code_unit, end_of_text, output ready);
endinterface

interface utx_out_if import utx_pkg::*; ;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       text_end;
  status_e    status;

  modport source (output valid, out_byte, last_of_run, text_end, status, input ready);
  modport sink (input valid, out_byte, last_of_run, text_end, status, output ready);
endinterface

interface utx_cfg_if;
  logic valid;
  logic ready;
  logic input_mode;

  modport source (output valid, input_mode, input ready);
  modport sink (input valid, input_mode, output ready);
endinterface

// File: sv/utx_front.sv
// Front end: accepts code units, tracks surrogate pairs and drop state,
// and pushes encode or error words into the queue. Depends on utx_pkg, utx_if.
`timescale 1ns / 1ps

module utx_front import utx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  utx_in_if.sink    in_i,
  utx_cfg_if.sink   cfg_i,
  input  logic      q_ready_i,
  output logic      push_o,
  output job_t      job_o
);

  logic       mode_q;
  logic       pend_q, pend_d;
  logic [9:0] hb_q, hb_d;
  logic       disc_q, disc_d;

  logic        fire, eot;
  logic [15:0] unit16;
  logic        is_hi, is_lo, wide_bad;
  logic        err, enc;
  status_e     err_status;
  logic [20:0] cp;

  assign in_i.ready  = q_ready_i;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    fire     = in_i.valid && in_i.ready;
    eot      = in_i.end_of_text;
    unit16   = in_i.code_unit[15:0];
    is_hi    = unit16 inside {[SurHiFirst:SurHiLast]};
    is_lo    = unit16 inside {[SurLoFirst:SurLoLast]};
    wide_bad = (in_i.code_unit > MaxCodePoint) ||
               (in_i.code_unit inside {[{16'h0, SurHiFirst}:{16'h0, SurLoLast}]});

    err        = 1'b0;
    enc        = 1'b0;
    err_status = ST_OK;
    cp         = {5'd0, unit16};
    pend_d     = pend_q;
    hb_d       = hb_q;
    disc_d     = disc_q;

    if (fire) begin
      if (disc_q) begin
        disc_d = !eot;
      end else if (mode_q) begin
        cp = in_i.code_unit[20:0];
        if (pend_q) begin
          err        = 1'b1;
          err_status = ST_BAD_PAIR;
        end else if (wide_bad) begin
          err        = 1'b1;
          err_status = ST_INVALID;
        end else begin
          enc = 1'b1;
        end
      end else if (pend_q) begin
        if (!is_lo) begin
          err        = 1'b1;
          err_status = ST_BAD_PAIR;
        end else begin
          enc    = 1'b1;
          cp     = SuppBase + {1'b0, hb_q, unit16[9:0]};
          pend_d = 1'b0;
          hb_d   = '0;
        end
      end else if (is_hi) begin
        if (eot) begin
          err        = 1'b1;
          err_status = ST_TRUNCATED;
        end else begin
          pend_d = 1'b1;
          hb_d   = unit16[9:0];
        end
      end else if (is_lo) begin
        err        = 1'b1;
        err_status = ST_LONE_LOW;
      end else begin
        enc = 1'b1;
      end
    end

    if (err) begin
      pend_d = 1'b0;
      hb_d   = '0;
      disc_d = !eot;
    end

    push_o          = err || enc;
    job_o.cp        = err ? '0 : cp;
    job_o.last_idx  = err ? 2'd0 : utf8_last_idx(cp);
    job_o.eot       = err ? 1'b1 : eot;
    job_o.status    = err_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      pend_q <= 1'b0;
      hb_q   <= '0;
      disc_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        mode_q <= cfg_i.input_mode;
      end
      pend_q <= pend_d;
      hb_q   <= hb_d;
      disc_q <= disc_d;
    end
  end

  // a held surrogate is dropped whenever an error starts discarding
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pend_q && disc_q))
    else $error("utx_front: surrogate held while discarding");

endmodule

// File: sv/utx_queue.sv
// Small word queue between the front end and the byte emitter.
// Depends on utx_pkg for the word type.
`timescale 1ns / 1ps

module utx_queue import utx_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = cnt_q != CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    do_push = push_i && ready_o;
    do_pop  = pop_i && valid_o;
    wr_d    = wr_q;
    rd_d    = rd_q;
    cnt_d   = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + IdxW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + IdxW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> ready_o)
    else $error("utx_queue: push while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("utx_queue: fill count out of range");

endmodule

// File: sv/utx_back.sv
// Byte emitter: walks the queue head into a registered output stage,
// one UTF-8 byte per cycle unless stalled. Depends on utx_pkg, utx_if.
`timescale 1ns / 1ps

module utx_back import utx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_i,
  output logic      pop_o,
  utx_out_if.source out_o
);

  logic       vld_q, vld_d;
  logic [1:0] idx_q, idx_d;
  logic [7:0] byte_q;
  logic       last_q, end_q;
  status_e    st_q;

  logic       load, take, last;
  logic [1:0] from_end;
  logic [5:0] six;
  logic [7:0] byte_d;

  assign out_o.valid       = vld_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.last_of_run = last_q;
  assign out_o.text_end    = end_q;
  assign out_o.status      = st_q;

  always_comb begin
    load     = !vld_q || out_o.ready;
    take     = load && head_valid_i;
    last     = idx_q == head_i.last_idx;
    pop_o    = take && last;
    from_end = head_i.last_idx - idx_q;

    case (from_end)
      2'd0:    six = head_i.cp[5:0];
      2'd1:    six = head_i.cp[11:6];
      2'd2:    six = head_i.cp[17:12];
      default: six = head_i.cp[5:0];
    endcase

    if (idx_q == 2'd0) begin
      case (head_i.last_idx)
        2'd0:    byte_d = {1'b0, head_i.cp[6:0]};
        2'd1:    byte_d = Lead2 | {3'd0, head_i.cp[10:6]};
        2'd2:    byte_d = Lead3 | {4'd0, head_i.cp[15:12]};
        default: byte_d = Lead4 | {5'd0, head_i.cp[20:18]};
      endcase
    end else begin
      byte_d = ContMark | {2'd0, six & ContMask};
    end

    vld_d = take ? 1'b1 : (out_o.ready ? 1'b0 : vld_q);
    idx_d = take ? (last ? 2'd0 : idx_q + 2'd1) : idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= byte_d;
      last_q <= last;
      end_q  <= last && head_i.eot;
      st_q   <= head_i.status;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !head_valid_i |-> idx_q == 2'd0)
    else $error("utx_back: byte index left over with empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   head_valid_i |-> idx_q <= head_i.last_idx)
    else $error("utx_back: byte index past end of code point");

endmodule

// File: sv/utf16_utf32_to_utf8_transcoder.sv
// Top level of the UTF-16/UTF-32 to UTF-8 transcoder: front end, word queue, byte emitter.
// Accepted items go to the word queue; their bytes are then registered in the output stage.
// Throughput: one output byte per cycle while the output is ready, one to four bytes per
// item; held high surrogates and dropped units produce no byte. Bounded by the emitter.
// Reset (async, active low) clears pair and drop state, selects UTF-16 mode, empties the queue.
`timescale 1ns / 1ps

module utf16_utf32_to_utf8_transcoder import utx_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  utx_in_if.sink    in_i,
  utx_cfg_if.sink   cfg_i,
  utx_out_if.source out_o
);

  logic push, q_ready, head_valid, pop;
  job_t push_job, head_job;

  utx_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .job_o     (push_job)
  );

  utx_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .data_o      (head_job)
  );

  utx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
